// File: rtl/core/sba_pkg.sv
// Shared types and constants for the skyline block allocator.
// Depends on nothing; used by the allocator top level.
package sba_pkg;

  // Default geometry of the page set.
  localparam int unsigned NumPagesDef   = 64;
  localparam int unsigned PageWidthDef  = 128;
  localparam int unsigned PageHeightDef = 128;

  // Field widths of the stream items.
  localparam int unsigned RectW    = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned PageIdxW = 6;
  localparam int unsigned PosXW    = 7;
  localparam int unsigned PosYW    = 7;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_DONE     = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_WRITE,
    S_OUT
  } state_e;

endpackage

// File: rtl/core/sba_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module sba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/core/skyline_block_allocator_top.sv
// Skyline rectangle allocator: sequencer, skyline store and result register.
// Depends on sba_pkg and sba_ram.
//
//  Channel | Dir | tdata (low bit up)                      | tuser
//  s_axis  | in  | rect_width[7:0], rect_height[15:8]      | req_type[0]
//  m_axis  | out | page_index[5:0], pos_x[12:6], pos_y[19:13] | status[1:0]
//
// One request is worked at a time; s_axis_tready is high only while idle.
// An allocate reads one column at a time on the single RAM port (S_READ, then S_CMP)
// for each page tried, then writes each column raised in S_WRITE.
// A scan start is skipped past any column that already reaches the best height.
// A clear request, and the time after reset, sweep all NUM_PAGES*PAGE_WIDTH
// entries at one per cycle (8192 entries by default) before the block is ready.
// A result waits in its register until m_axis_tready takes it.
module skyline_block_allocator_top #(
  parameter int unsigned NUM_PAGES   = sba_pkg::NumPagesDef,
  parameter int unsigned PAGE_WIDTH  = sba_pkg::PageWidthDef,
  parameter int unsigned PAGE_HEIGHT = sba_pkg::PageHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // rect_width[7:0], rect_height[15:8]
  input  logic [sba_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // page_index[5:0], pos_x[12:6], pos_y[19:13], zero fill above
  output logic [sba_pkg::OutDataW-1:0]  m_axis_tdata,
  // status[1:0]
  output logic [sba_pkg::StatusW-1:0]   m_axis_tuser
);

  localparam int unsigned Depth = NUM_PAGES * PAGE_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(PAGE_WIDTH + 1);
  localparam int unsigned HW    = $clog2(PAGE_HEIGHT + 1);
  localparam int unsigned PGW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

  sba_pkg::state_e state_q, state_d;

  logic [AW-1:0]  clr_q, clr_d;
  logic           reply_q, reply_d;
  logic [PGW-1:0] page_q, page_d;
  logic [AW-1:0]  base_q, base_d;
  logic [CW-1:0]  col_q, col_d;
  logic [CW-1:0]  start_q, start_d;
  logic [HW-1:0]  top_q, top_d;
  logic [HW-1:0]  best_q, best_d;
  logic [CW-1:0]  bestx_q, bestx_d;
  logic           found_q, found_d;
  logic [CW-1:0]  w_q, w_d;
  logic [HW-1:0]  h_q, h_d;

  logic [sba_pkg::StatusW-1:0]  st_q, st_d;
  logic [sba_pkg::PageIdxW-1:0] pg_q, pg_d;
  logic [sba_pkg::PosXW-1:0]    x_q, x_d;
  logic [sba_pkg::PosYW-1:0]    y_q, y_d;

  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [HW-1:0]             ram_wdata;
  logic [HW-1:0]             ram_rdata;

  logic [sba_pkg::RectW-1:0] in_w, in_h;
  logic [HW-1:0]             thr_c, max_c;
  logic [CW-1:0]             last_start_c, win_end_c, col_nxt_c;
  logic                      page_end, hit;
  logic [CW-1:0]             hit_x;
  logic [HW-1:0]             hit_y;

  assign in_w = s_axis_tdata[7:0];
  assign in_h = s_axis_tdata[15:8];

  // A start whose top would not leave room for the rectangle can never be used,
  // so the best height starts just above the highest usable top.
  assign thr_c        = HW'(PAGE_HEIGHT) - h_q + HW'(1);
  assign last_start_c = CW'(PAGE_WIDTH - 1) - w_q;
  assign win_end_c    = start_q + w_q - CW'(1);
  assign col_nxt_c    = col_q + CW'(1);
  assign max_c        = (ram_rdata > top_q) ? ram_rdata : top_q;

  sba_ram #(
    .WIDTH(HW),
    .DEPTH(Depth)
  ) u_heights (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    reply_d   = reply_q;
    page_d    = page_q;
    base_d    = base_q;
    col_d     = col_q;
    start_d   = start_q;
    top_d     = top_q;
    best_d    = best_q;
    bestx_d   = bestx_q;
    found_d   = found_q;
    w_d       = w_q;
    h_d       = h_q;
    st_d      = st_q;
    pg_d      = pg_q;
    x_d       = x_q;
    y_d       = y_q;
    ram_we    = 1'b0;
    ram_addr  = base_q + AW'(col_q);
    ram_wdata = best_q + h_q;
    page_end  = 1'b0;
    hit       = found_q;
    hit_x     = bestx_q;
    hit_y     = best_q;

    case (state_q)
      sba_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          clr_d = '0;
          if (reply_q) begin
            reply_d = 1'b0;
            st_d    = sba_pkg::ST_DONE;
            pg_d    = '0;
            x_d     = '0;
            y_d     = '0;
            state_d = sba_pkg::S_OUT;
          end else begin
            state_d = sba_pkg::S_IDLE;
          end
        end
      end

      sba_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          pg_d = '0;
          x_d  = '0;
          y_d  = '0;
          if (s_axis_tuser == sba_pkg::REQ_CLEAR) begin
            reply_d = 1'b1;
            clr_d   = '0;
            state_d = sba_pkg::S_CLEAR;
          end else if (in_w == '0 || in_h == '0) begin
            st_d    = sba_pkg::ST_BAD_SIZE;
            state_d = sba_pkg::S_OUT;
          end else if (32'(in_w) >= 32'(PAGE_WIDTH) || 32'(in_h) > 32'(PAGE_HEIGHT)) begin
            st_d    = sba_pkg::ST_FULL;
            state_d = sba_pkg::S_OUT;
          end else begin
            w_d     = CW'(in_w);
            h_d     = HW'(in_h);
            best_d  = HW'(PAGE_HEIGHT) - HW'(in_h) + HW'(1);
            page_d  = '0;
            base_d  = '0;
            col_d   = '0;
            start_d = '0;
            top_d   = '0;
            found_d = 1'b0;
            state_d = sba_pkg::S_READ;
          end
        end
      end

      sba_pkg::S_READ: begin
        state_d = sba_pkg::S_CMP;
      end

      sba_pkg::S_CMP: begin
        state_d = sba_pkg::S_READ;
        if (ram_rdata >= best_q) begin
          // Every start up to this column covers it and cannot beat the best.
          if (col_nxt_c > last_start_c) begin
            page_end = 1'b1;
          end else begin
            start_d = col_nxt_c;
            col_d   = col_nxt_c;
            top_d   = '0;
          end
        end else if (col_q == win_end_c) begin
          best_d  = max_c;
          bestx_d = start_q;
          found_d = 1'b1;
          hit     = 1'b1;
          hit_x   = start_q;
          hit_y   = max_c;
          if (start_q == last_start_c) begin
            page_end = 1'b1;
          end else begin
            start_d = start_q + CW'(1);
            col_d   = start_q + CW'(1);
            top_d   = '0;
          end
        end else begin
          col_d = col_nxt_c;
          top_d = max_c;
        end

        if (page_end) begin
          if (hit) begin
            col_d   = hit_x;
            bestx_d = hit_x;
            best_d  = hit_y;
            state_d = sba_pkg::S_WRITE;
          end else if (page_q == PGW'(NUM_PAGES - 1)) begin
            st_d    = sba_pkg::ST_FULL;
            pg_d    = '0;
            x_d     = '0;
            y_d     = '0;
            state_d = sba_pkg::S_OUT;
          end else begin
            page_d  = page_q + PGW'(1);
            base_d  = base_q + AW'(PAGE_WIDTH);
            col_d   = '0;
            start_d = '0;
            top_d   = '0;
            best_d  = thr_c;
          end
        end
      end

      sba_pkg::S_WRITE: begin
        ram_we = 1'b1;
        col_d  = col_nxt_c;
        if (col_q == bestx_q + w_q - CW'(1)) begin
          st_d    = sba_pkg::ST_DONE;
          pg_d    = sba_pkg::PageIdxW'(page_q);
          x_d     = sba_pkg::PosXW'(bestx_q);
          y_d     = sba_pkg::PosYW'(best_q);
          state_d = sba_pkg::S_OUT;
        end
      end

      sba_pkg::S_OUT: begin
        if (m_axis_tready) begin
          state_d = sba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sba_pkg::S_CLEAR;
      clr_q   <= '0;
      reply_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      reply_q <= reply_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    base_q  <= base_d;
    col_q   <= col_d;
    start_q <= start_d;
    top_q   <= top_d;
    best_q  <= best_d;
    bestx_q <= bestx_d;
    w_q     <= w_d;
    h_q     <= h_d;
    st_q    <= st_d;
    pg_q    <= pg_d;
    x_q     <= x_d;
    y_q     <= y_d;
  end

  assign s_axis_tready = (state_q == sba_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == sba_pkg::S_OUT);
  assign m_axis_tuser  = st_q;
  assign m_axis_tdata  = {4'b0000, y_q, x_q, pg_q};

  // The block never takes a request while a result is pending.
  a_no_accept_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // Every column already in the window is below the best height so far, unless
  // the window is still empty at a best height of zero.
  a_window_below_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sba_pkg::S_CMP) |-> ((top_q < best_q) || (top_q == '0)))
    else $error("window maximum not below best height");

  // A placed rectangle stays clear of the last column and inside the page height.
  a_placement_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sba_pkg::S_WRITE) |->
      ((32'(bestx_q) + 32'(w_q) <= 32'(PAGE_WIDTH - 1)) &&
       (32'(best_q) + 32'(h_q) <= 32'(PAGE_HEIGHT))))
    else $error("placement outside the page");

endmodule
